FILE: hw/rtl/ubx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UBX receiver package
// Parse phases, sync bytes, drop codes, register indexes and shared structs.
// ----------------------------------------------------------------------------
package ubx_pkg;

    localparam logic [7:0] SYNC_FIRST     = 8'hB5;
    localparam logic [7:0] SYNC_SECOND    = 8'h62;
    localparam int         FRAME_OVERHEAD = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECT_CLASS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECT_ID     = 2'd2;

    localparam logic [1:0] DROP_NONE    = 2'd0;
    localparam logic [1:0] DROP_TOO_LONG = 2'd1;
    localparam logic [1:0] DROP_CKA     = 2'd2;
    localparam logic [1:0] DROP_CKB     = 2'd3;

    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LENL    = 4'd4,
        PH_LENH    = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CKA     = 4'd7,
        PH_CKB     = 4'd8
    } phase_t;

    typedef struct packed {
        logic [9:0] max_frame_len;
        logic [7:0] expect_class;
        logic [7:0] expect_id;
    } cfg_t;

    typedef struct packed {
        logic       store_valid;
        logic [8:0] store_index;
        logic [7:0] store_byte;
        logic       frame_good;
        logic       frame_match;
        logic [9:0] frame_length;
        logic [7:0] frame_class;
        logic [7:0] frame_id;
        logic [1:0] drop_reason;
    } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ubx_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UBX receiver channels
// Byte input, result output and register write channels.
// ----------------------------------------------------------------------------
interface ubx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ubx_result_if;
    logic       valid;
    logic       ready;
    logic       store_valid;
    logic [8:0] store_index;
    logic [7:0] store_byte;
    logic       frame_good;
    logic       frame_match;
    logic [9:0] frame_length;
    logic [7:0] frame_class;
    logic [7:0] frame_id;
    logic [1:0] drop_reason;

    modport source (output valid, output store_valid, output store_index,
                    output store_byte, output frame_good, output frame_match,
                    output frame_length, output frame_class, output frame_id,
                    output drop_reason, input ready);
    modport sink   (input valid, input store_valid, input store_index,
                    input store_byte, input frame_good, input frame_match,
                    input frame_length, input frame_class, input frame_id,
                    input drop_reason, output ready);
endinterface

interface ubx_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [9:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ubx_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted byte is held in the input register, parsed combinationally,
// and its result item is registered in the result register.
// Throughput: one byte per cycle unless res.ready stalls; the input and result
// registers each advance whenever the result register is empty or being taken.
// Reset: asynchronous, active low; parser waits for first sync, sums and
// counters clear, registers return to max_frame_len 512, class and id 0.
// ----------------------------------------------------------------------------
// UBX frame receiver
// Byte-serial binary GNSS frame parser with Fletcher-8 check and length limit.
// ----------------------------------------------------------------------------
module ubx_frame_receiver
    import ubx_pkg::*;
#(
    parameter int BUFFER_BYTES = 512
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    ubx_byte_if.sink     rx,
    ubx_result_if.source res,
    ubx_cfg_if.sink      cfg
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    byte_valid;
    logic [7:0] byte_data;
    logic    advance;
    logic    fire;
    result_t result;

    assign cfg.ready = 1'b1;
    assign fire      = byte_valid && advance;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_MAX_FRAME_LEN: cfg_next.max_frame_len = cfg.data;
                CFG_EXPECT_CLASS:  cfg_next.expect_class  = cfg.data[7:0];
                CFG_EXPECT_ID:     cfg_next.expect_id     = cfg.data[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_frame_len <= 10'd512;
            cfg_reg.expect_class  <= 8'd0;
            cfg_reg.expect_id     <= 8'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ubx_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    ubx_parser #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .rx_byte (byte_data),
        .cfg     (cfg_reg),
        .result  (result)
    );

    ubx_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (byte_valid),
        .load_data  (result),
        .advance    (advance),
        .res        (res)
    );

`ifndef ASSERT_OFF
    a_good_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.frame_good |-> res.store_valid && res.drop_reason == DROP_NONE)
        else $error("good frame flagged with drop or without store");

    a_match_good: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.frame_match |-> res.frame_good)
        else $error("match without good frame");

    a_unstored_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.store_valid |-> res.store_index == 9'd0 && res.store_byte == 8'd0)
        else $error("unstored byte carries index or data");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !advance |-> !rx.ready)
        else $error("input taken while held byte is stalled");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res.valid)
        else $error("parsed byte produced no result");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/ubx_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UBX input register
// Captures one received byte and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module ubx_in_reg
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ubx_byte_if.sink   rx,
    input  wire logic  advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign rx.ready   = !valid_reg || advance;
    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (rx.ready)
        begin
            valid_next = rx.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/ubx_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UBX frame parser
// Frame state machine, Fletcher-8 sums and per-byte result computation.
// ----------------------------------------------------------------------------
module ubx_parser
    import ubx_pkg::*;
#(
    parameter int BUFFER_BYTES = 512
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    fire,
    input  wire logic [7:0] rx_byte,
    input  wire cfg_t    cfg,
    output result_t      result
);

    localparam logic [16:0] BUF_LIMIT = 17'(BUFFER_BYTES);
    localparam logic [16:0] OVERHEAD  = 17'(FRAME_OVERHEAD);

    phase_t      phase_reg,   phase_next;
    logic [9:0]  wpos_reg,    wpos_next;
    logic [15:0] plen_reg,    plen_next;
    logic [15:0] pcnt_reg,    pcnt_next;
    logic [7:0]  sum_a_reg,   sum_a_next;
    logic [7:0]  sum_b_reg,   sum_b_next;
    logic [7:0]  class_reg,   class_next;
    logic [7:0]  id_reg,      id_next;

    logic [7:0]  sum_a_add;
    logic [7:0]  sum_b_add;
    logic [15:0] plen_full;
    logic [15:0] pcnt_inc;
    logic [16:0] limit;
    logic [16:0] total_len;
    logic [15:0] good_len;
    logic        store;
    logic [9:0]  index;
    logic        good;
    logic        match;
    logic [1:0]  drop;

    assign sum_a_add = sum_a_reg + rx_byte;
    assign sum_b_add = sum_b_reg + sum_a_add;
    assign plen_full = {rx_byte, plen_reg[7:0]};
    assign pcnt_inc  = pcnt_reg + 16'd1;
    assign limit     = ({7'd0, cfg.max_frame_len} > BUF_LIMIT) ?
                       BUF_LIMIT : {7'd0, cfg.max_frame_len};
    assign total_len = {1'b0, plen_full} + OVERHEAD;
    assign good_len  = plen_reg + 16'(FRAME_OVERHEAD);

    always_comb
    begin
        phase_next = phase_reg;
        wpos_next  = wpos_reg;
        plen_next  = plen_reg;
        pcnt_next  = pcnt_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        class_next = class_reg;
        id_next    = id_reg;
        store      = 1'b0;
        index      = 10'd0;
        good       = 1'b0;
        match      = 1'b0;
        drop       = DROP_NONE;

        case (phase_reg)
            PH_SYNC2:
            begin
                if (rx_byte == SYNC_SECOND)
                begin
                    store      = 1'b1;
                    index      = wpos_reg;
                    wpos_next  = wpos_reg + 10'd1;
                    phase_next = PH_CLASS;
                end
                else if (rx_byte == SYNC_FIRST)
                begin
                    store     = 1'b1;
                    wpos_next = 10'd1;
                end
                else
                begin
                    wpos_next  = 10'd0;
                    phase_next = PH_SYNC1;
                end
            end
            PH_CLASS:
            begin
                store      = 1'b1;
                index      = wpos_reg;
                wpos_next  = wpos_reg + 10'd1;
                sum_a_next = rx_byte;
                sum_b_next = rx_byte;
                class_next = rx_byte;
                phase_next = PH_ID;
            end
            PH_ID:
            begin
                store      = 1'b1;
                index      = wpos_reg;
                wpos_next  = wpos_reg + 10'd1;
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                id_next    = rx_byte;
                phase_next = PH_LENL;
            end
            PH_LENL:
            begin
                store      = 1'b1;
                index      = wpos_reg;
                wpos_next  = wpos_reg + 10'd1;
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                plen_next  = {8'd0, rx_byte};
                phase_next = PH_LENH;
            end
            PH_LENH:
            begin
                store      = 1'b1;
                index      = wpos_reg;
                wpos_next  = wpos_reg + 10'd1;
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                plen_next  = plen_full;
                if (total_len > limit)
                begin
                    drop       = DROP_TOO_LONG;
                    phase_next = PH_SYNC1;
                    wpos_next  = 10'd0;
                end
                else if (plen_full == 16'd0)
                begin
                    phase_next = PH_CKA;
                end
                else
                begin
                    pcnt_next  = 16'd0;
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                store      = 1'b1;
                index      = wpos_reg;
                wpos_next  = wpos_reg + 10'd1;
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                pcnt_next  = pcnt_inc;
                if (pcnt_inc == plen_reg)
                begin
                    phase_next = PH_CKA;
                end
            end
            PH_CKA:
            begin
                store     = 1'b1;
                index     = wpos_reg;
                wpos_next = wpos_reg + 10'd1;
                if (rx_byte == sum_a_reg)
                begin
                    phase_next = PH_CKB;
                end
                else
                begin
                    drop       = DROP_CKA;
                    phase_next = PH_SYNC1;
                    wpos_next  = 10'd0;
                end
            end
            PH_CKB:
            begin
                store = 1'b1;
                index = wpos_reg;
                if (rx_byte == sum_b_reg)
                begin
                    good  = 1'b1;
                    match = (class_reg == cfg.expect_class) && (id_reg == cfg.expect_id);
                end
                else
                begin
                    drop = DROP_CKB;
                end
                phase_next = PH_SYNC1;
                wpos_next  = 10'd0;
            end
            default:
            begin
                phase_next = PH_SYNC1;
                wpos_next  = 10'd0;
                if (rx_byte == SYNC_FIRST)
                begin
                    store      = 1'b1;
                    wpos_next  = 10'd1;
                    sum_a_next = 8'd0;
                    sum_b_next = 8'd0;
                    phase_next = PH_SYNC2;
                end
            end
        endcase
    end

    always_comb
    begin
        result.store_valid  = store;
        result.store_index  = index[8:0];
        result.store_byte   = store ? rx_byte : 8'd0;
        result.frame_good   = good;
        result.frame_match  = match;
        result.frame_length = good ? good_len[9:0] : 10'd0;
        result.frame_class  = class_next;
        result.frame_id     = id_next;
        result.drop_reason  = drop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC1;
            wpos_reg  <= 10'd0;
            plen_reg  <= 16'd0;
            pcnt_reg  <= 16'd0;
            sum_a_reg <= 8'd0;
            sum_b_reg <= 8'd0;
            class_reg <= 8'd0;
            id_reg    <= 8'd0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            wpos_reg  <= wpos_next;
            plen_reg  <= plen_next;
            pcnt_reg  <= pcnt_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            class_reg <= class_next;
            id_reg    <= id_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/ubx_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UBX result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module ubx_out_reg
    import ubx_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load_valid,
    input  wire result_t load_data,
    output logic         advance,
    ubx_result_if.source res
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign advance = !valid_reg || res.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = load_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load_valid)
        begin
            data_reg <= load_data;
        end
    end

    assign res.valid        = valid_reg;
    assign res.store_valid  = data_reg.store_valid;
    assign res.store_index  = data_reg.store_index;
    assign res.store_byte   = data_reg.store_byte;
    assign res.frame_good   = data_reg.frame_good;
    assign res.frame_match  = data_reg.frame_match;
    assign res.frame_length = data_reg.frame_length;
    assign res.frame_class  = data_reg.frame_class;
    assign res.frame_id     = data_reg.frame_id;
    assign res.drop_reason  = data_reg.drop_reason;

endmodule
`default_nettype wire
